>>> src/escd_pkg.sv
// escd_pkg: shared types, constants and calendar helpers for the epoch seconds
// to calendar date converter
// no dependencies
package escd_pkg;

    localparam int DEFAULT_SECONDS_BITS = 32;

    // result field widths
    localparam int YEAR_W  = 8;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int YDAY_W  = 9;
    localparam int WDAY_W  = 3;

    // time of day is below one day, so it fits in 17 bits
    localparam int TOD_W   = 17;
    localparam int SUBH_W  = 12;   // seconds within one hour
    localparam int EST_W   = 6;    // hour or minute estimate

    localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [SUBH_W-1:0] SECS_PER_MIN  = 12'd60;

    // 86400 = 675 * 2^7: drop the low seven bits, then divide by 675
    localparam int                    DAY_LOW_BITS = 7;
    localparam int                    DAY_ODD_W    = 10;
    localparam logic [DAY_ODD_W-1:0]  DAY_ODD      = 10'd675;
    // floor(2^36 / 675), low by at most one for inputs up to 33 bits
    localparam int                    DAY_RECIP_W  = 27;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP   = 27'd101806632;
    localparam int                    DAY_SHIFT    = 36;

    // reciprocals that never overestimate, so one correction step suffices
    localparam int HOUR_RECIP = 36;    // floor(2^17 / 3600)
    localparam int HOUR_SHIFT = 17;
    localparam int MIN_RECIP  = 68;    // floor(2^12 / 60)
    localparam int MIN_SHIFT  = 12;

    localparam logic [YDAY_W-1:0] DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [YDAY_W-1:0] DAYS_COMMON_YEAR = 9'd365;

    // 1970 as year offset from 1900 and as residues mod 4, 100 and 400
    localparam logic [YEAR_W-1:0] START_YEAR_OFS = 8'd70;
    localparam logic [1:0]        START_MOD4     = 2'd2;
    localparam logic [6:0]        START_MOD100   = 7'd70;
    localparam logic [8:0]        START_MOD400   = 9'd370;

    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
    localparam logic [WDAY_W-1:0]  EPOCH_WDAY = 3'd4;   // thursday

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_EST,
        ST_DAY_FIX,
        ST_HOUR_EST,
        ST_HOUR_FIX,
        ST_MIN_EST,
        ST_MIN_FIX,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic day_est;
        logic day_fix;
        logic hour_est;
        logic hour_fix;
        logic min_est;
        logic min_fix;
        logic year_step;
        logic month_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_dp_status;

    function automatic logic [4:0] month_days(input logic leap, input logic [MONTH_W-1:0] mon);
        logic [4:0] d;
        unique case (mon)
            4'd1:                      d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

>>> src/epoch_seconds_to_calendar_date.sv
// epoch_seconds_to_calendar_date: top level of the unix time to utc date converter
// ties escd_ctrl to escd_datapath; uses escd_pkg
//
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into the
// broken-down calendar time. One beat is in flight at a time: after acceptance
// the day count is split off (the low seven bits are dropped and the rest is
// divided by 675 with a reciprocal multiply and one correction), then the time
// of day is split into hours, then minutes and seconds, each by an estimate and
// a correction; the year walk then takes off one whole year since 1970 per cycle
// and the month walk one month per cycle, and the result is loaded once the
// output register is free. The next beat can be accepted in the cycle after the
// result is loaded. The finished result sits in an output register, so the next
// beat is taken while it waits to be collected. Only the low SECONDS_BITS bits
// of the input are used; the year field holds year - 1900 modulo 256.
module epoch_seconds_to_calendar_date #(
    parameter int SECONDS_BITS = escd_pkg::DEFAULT_SECONDS_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [SECONDS_BITS-1:0]            i_epoch_seconds,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [escd_pkg::YEAR_W-1:0]        o_year_since_1900,
    output logic [escd_pkg::MONTH_W-1:0]       o_month_index,
    output logic [escd_pkg::MDAY_W-1:0]        o_day_of_month,
    output logic [escd_pkg::HOUR_W-1:0]        o_hour_of_day,
    output logic [escd_pkg::MIN_W-1:0]         o_minute_of_hour,
    output logic [escd_pkg::SEC_W-1:0]         o_second_of_minute,
    output logic [escd_pkg::YDAY_W-1:0]        o_day_of_year,
    output logic [escd_pkg::WDAY_W-1:0]        o_weekday
);
    import escd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    escd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    escd_datapath #(
        .SECONDS_BITS(SECONDS_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_year_since_1900  (o_year_since_1900),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute),
        .o_day_of_year      (o_day_of_year),
        .o_weekday          (o_weekday)
    );

endmodule

>>> src/escd_ctrl.sv
// escd_ctrl: sequencer for the epoch seconds converter
// drives the datapath commands and owns both channel handshakes; uses escd_pkg
module escd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  escd_pkg::t_dp_status i_status,
    output escd_pkg::t_dp_cmd    o_cmd
);
    import escd_pkg::*;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_DAY_EST;
            ST_DAY_EST:  n_state = ST_DAY_FIX;
            ST_DAY_FIX:  n_state = ST_HOUR_EST;
            ST_HOUR_EST: n_state = ST_HOUR_FIX;
            ST_HOUR_FIX: n_state = ST_MIN_EST;
            ST_MIN_EST:  n_state = ST_MIN_FIX;
            ST_MIN_FIX:  n_state = ST_YEAR;
            ST_YEAR:     if (i_status.year_done) n_state = ST_MONTH;
            ST_MONTH:    if (i_status.month_done) n_state = ST_DONE;
            ST_DONE:     if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:     o_cmd.load       = i_valid;
            ST_DAY_EST:  o_cmd.day_est    = 1'b1;
            ST_DAY_FIX:  o_cmd.day_fix    = 1'b1;
            ST_HOUR_EST: o_cmd.hour_est   = 1'b1;
            ST_HOUR_FIX: o_cmd.hour_fix   = 1'b1;
            ST_MIN_EST:  o_cmd.min_est    = 1'b1;
            ST_MIN_FIX:  o_cmd.min_fix    = 1'b1;
            ST_YEAR:     o_cmd.year_step  = 1'b1;
            ST_MONTH:    o_cmd.month_step = 1'b1;
            ST_DONE:     o_cmd.out_load   = !r_out_valid || i_ready;
            default:     o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/escd_datapath.sv
// escd_datapath: reciprocal split of the day count and the time of day, year
// and month subtraction walk and result registers; uses escd_pkg
module escd_datapath #(
    parameter int SECONDS_BITS = escd_pkg::DEFAULT_SECONDS_BITS
) (
    input  logic                               i_clk,
    input  escd_pkg::t_dp_cmd                  i_cmd,
    output escd_pkg::t_dp_status               o_status,
    input  logic [SECONDS_BITS-1:0]            i_epoch_seconds,
    output logic [escd_pkg::YEAR_W-1:0]        o_year_since_1900,
    output logic [escd_pkg::MONTH_W-1:0]       o_month_index,
    output logic [escd_pkg::MDAY_W-1:0]        o_day_of_month,
    output logic [escd_pkg::HOUR_W-1:0]        o_hour_of_day,
    output logic [escd_pkg::MIN_W-1:0]         o_minute_of_hour,
    output logic [escd_pkg::SEC_W-1:0]         o_second_of_minute,
    output logic [escd_pkg::YDAY_W-1:0]        o_day_of_year,
    output logic [escd_pkg::WDAY_W-1:0]        o_weekday
);
    import escd_pkg::*;

    // 86400 exceeds 2^16, so the day count needs 16 fewer bits than the input
    localparam int DAYS_W = SECONDS_BITS - 16;
    localparam int XW     = SECONDS_BITS - DAY_LOW_BITS;
    localparam int DPW    = XW + DAY_RECIP_W;
    // octal digits of the day count, their sum stays below 64
    localparam int OCT_N  = (DAYS_W + 2) / 3;

    logic [XW-1:0]           r_x;
    logic [DAY_LOW_BITS-1:0] r_lo;
    logic [TOD_W-1:0]        r_tod;
    logic [DAYS_W-1:0]       r_days;
    logic [2:0]              r_w7;
    logic [EST_W-1:0]        r_est;
    logic [HOUR_W-1:0]       r_hour;
    logic [SUBH_W-1:0]       r_subh;
    logic [MIN_W-1:0]        r_min;
    logic [SEC_W-1:0]        r_sec;
    logic [YEAR_W-1:0]       r_yofs;
    logic [1:0]              r_m4;
    logic [6:0]              r_m100;
    logic [8:0]              r_m400;
    logic [YDAY_W-1:0]       r_yday;
    logic [MONTH_W-1:0]      r_mon;

    // day count split
    logic [DPW-1:0]          dprod_est;
    logic [XW-1:0]           dprod;
    logic [XW-1:0]           ddiff;
    logic [DAY_ODD_W:0]      drem;

    // day count mod 7, since 8 is 1 mod 7 the octal digits are summed
    logic [3*OCT_N-1:0]      days_oct;
    logic [5:0]              oct_sum;
    logic [3:0]              oct_fold;
    logic [3:0]              oct_fold2;
    logic [2:0]              days_mod7;

    // time of day split
    logic [TOD_W+5:0]        hprod;
    logic [TOD_W-1:0]        hrem;
    logic [SUBH_W+6:0]       mprod;
    logic [SUBH_W-1:0]       mrem;

    // walk
    logic                    leap;
    logic [YDAY_W-1:0]       ylen;
    logic                    take_year;
    logic [4:0]              mlen;
    logic                    take_month;
    logic [3:0]              wsum;

    assign dprod_est = DPW'(r_x) * DPW'(DAY_RECIP);
    assign dprod     = XW'(r_days) * XW'(DAY_ODD);
    assign ddiff     = r_x - dprod;
    assign drem      = ddiff[DAY_ODD_W:0];

    assign days_oct = (3*OCT_N)'(r_days);

    always_comb begin
        oct_sum = '0;
        for (int k = 0; k < OCT_N; k++) begin
            oct_sum = oct_sum + {3'b0, days_oct[3*k +: 3]};
        end
    end

    assign oct_fold  = {1'b0, oct_sum[5:3]} + {1'b0, oct_sum[2:0]};
    assign oct_fold2 = {3'b0, oct_fold[3]} + {1'b0, oct_fold[2:0]};
    assign days_mod7 = (oct_fold2 >= 4'd7) ? 3'(oct_fold2 - 4'd7) : oct_fold2[2:0];

    assign hprod = (TOD_W+6)'(r_tod) * (TOD_W+6)'(HOUR_RECIP);
    assign hrem  = r_tod - TOD_W'(r_est) * SECS_PER_HOUR;
    assign mprod = (SUBH_W+7)'(r_subh) * (SUBH_W+7)'(MIN_RECIP);
    assign mrem  = r_subh - SUBH_W'(r_est) * SECS_PER_MIN;

    assign leap       = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);
    assign ylen       = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign take_year  = (r_days >= DAYS_W'(ylen));
    assign mlen       = month_days(leap, r_mon);
    assign take_month = (r_mon != LAST_MONTH) && (r_days >= DAYS_W'(mlen));

    assign o_status.year_done  = !take_year;
    assign o_status.month_done = !take_month;

    assign wsum = {1'b0, r_w7} + {1'b0, EPOCH_WDAY};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_epoch_seconds[SECONDS_BITS-1:DAY_LOW_BITS];
            r_lo   <= i_epoch_seconds[DAY_LOW_BITS-1:0];
            r_yofs <= START_YEAR_OFS;
            r_m4   <= START_MOD4;
            r_m100 <= START_MOD100;
            r_m400 <= START_MOD400;
            r_mon  <= '0;
        end
        if (i_cmd.day_est) begin
            r_days <= dprod_est[DAY_SHIFT +: DAYS_W];
        end
        // estimate is low by at most one day
        if (i_cmd.day_fix) begin
            if (drem >= {1'b0, DAY_ODD}) begin
                r_days <= r_days + 1'b1;
                r_tod  <= {DAY_ODD_W'(drem - {1'b0, DAY_ODD}), r_lo};
            end else begin
                r_tod  <= {drem[DAY_ODD_W-1:0], r_lo};
            end
        end
        if (i_cmd.hour_est) begin
            r_est <= hprod[HOUR_SHIFT +: EST_W];
            r_w7  <= days_mod7;
        end
        if (i_cmd.hour_fix) begin
            if (hrem >= SECS_PER_HOUR) begin
                r_hour <= HOUR_W'(r_est) + 1'b1;
                r_subh <= SUBH_W'(hrem - SECS_PER_HOUR);
            end else begin
                r_hour <= HOUR_W'(r_est);
                r_subh <= hrem[SUBH_W-1:0];
            end
        end
        if (i_cmd.min_est) begin
            r_est <= mprod[MIN_SHIFT +: EST_W];
        end
        if (i_cmd.min_fix) begin
            if (mrem >= SECS_PER_MIN) begin
                r_min <= r_est + 1'b1;
                r_sec <= SEC_W'(mrem - SECS_PER_MIN);
            end else begin
                r_min <= r_est;
                r_sec <= mrem[SEC_W-1:0];
            end
        end
        if (i_cmd.year_step) begin
            if (take_year) begin
                r_days <= r_days - DAYS_W'(ylen);
                r_yofs <= r_yofs + 1'b1;
                r_m4   <= r_m4 + 1'b1;
                r_m100 <= (r_m100 == 7'd99)  ? 7'd0 : r_m100 + 1'b1;
                r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 1'b1;
            end else begin
                r_yday <= r_days[YDAY_W-1:0];
            end
        end
        if (i_cmd.month_step && take_month) begin
            r_days <= r_days - DAYS_W'(mlen);
            r_mon  <= r_mon + 1'b1;
        end
        if (i_cmd.out_load) begin
            o_year_since_1900  <= r_yofs;
            o_month_index      <= r_mon;
            o_day_of_month     <= r_days[MDAY_W-1:0] + 1'b1;
            o_hour_of_day      <= r_hour;
            o_minute_of_hour   <= r_min;
            o_second_of_minute <= r_sec;
            o_day_of_year      <= r_yday;
            o_weekday          <= (wsum >= 4'd7) ? WDAY_W'(wsum - 4'd7) : wsum[WDAY_W-1:0];
        end
    end

endmodule

>>> tb/tb_epoch_seconds_to_calendar_date.sv
// tb_epoch_seconds_to_calendar_date: self-checking bench for the unix time to utc date converter
// holds its own calendar predictor and a scoreboard class; needs escd_pkg and the top level
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_date;

    import escd_pkg::*;

    localparam int SECONDS_BITS     = 32;
    localparam int RANDOM_PER_PHASE = 450;
    localparam int DRAIN_CYCLES     = 250;
    localparam longint unsigned CYCLE_LIMIT = 3_000_000;
    localparam longint unsigned MAX_EPOCH   = 64'hFFFF_FFFF;

    // idle and stall percentages per phase: none, sender, receiver, both
    localparam int PHASE_IDLE  [4] = '{0, 65, 0, 32};
    localparam int PHASE_STALL [4] = '{0, 0, 65, 32};

    typedef struct packed {
        logic [SECONDS_BITS-1:0] epoch;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [MDAY_W-1:0]       mday;
        logic [HOUR_W-1:0]       hour;
        logic [MIN_W-1:0]        minute;
        logic [SEC_W-1:0]        second;
        logic [YDAY_W-1:0]       yday;
        logic [WDAY_W-1:0]       wday;
    } t_cal_date;

    class t_date_scoreboard;
        t_cal_date   pending_dates[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned month_len(bit leap, int unsigned m);
            case (m)
                1:          return leap ? 29 : 28;
                3, 5, 8, 10: return 30;
                default:    return 31;
            endcase
        endfunction

        // seconds at midnight of the given date, month counted from 0
        static function longint unsigned epoch_of(int unsigned y, int unsigned m,
                                                  int unsigned d);
            longint unsigned days;
            days = 0;
            for (int unsigned yy = 1970; yy < y; yy++) begin
                days += leap_year(yy) ? 366 : 365;
            end
            for (int unsigned mm = 0; mm < m; mm++) begin
                days += month_len(leap_year(y), mm);
            end
            days += d - 1;
            return days * 86400;
        endfunction

        function t_cal_date to_calendar_date(logic [SECONDS_BITS-1:0] t);
            longint unsigned days;
            longint unsigned tod;
            int unsigned     year;
            int unsigned     mon;
            bit              leap;
            t_cal_date       r;
            days     = t / 86400;
            tod      = t % 86400;
            r.epoch  = t;
            r.hour   = HOUR_W'(tod / 3600);
            r.minute = MIN_W'((tod % 3600) / 60);
            r.second = SEC_W'(tod % 60);
            // 1970-01-01 was a thursday
            r.wday   = WDAY_W'((days + 4) % 7);
            year = 1970;
            while (days >= (leap_year(year) ? 366 : 365)) begin
                days -= leap_year(year) ? 366 : 365;
                year++;
            end
            r.yday = YDAY_W'(days);
            leap = leap_year(year);
            mon  = 0;
            while (mon < 11 && days >= month_len(leap, mon)) begin
                days -= month_len(leap, mon);
                mon++;
            end
            r.year  = YEAR_W'(year - 1900);
            r.month = MONTH_W'(mon);
            r.mday  = MDAY_W'(days + 1);
            return r;
        endfunction

        function void note_epoch(logic [SECONDS_BITS-1:0] t);
            pending_dates.push_back(to_calendar_date(t));
        endfunction

        function int unsigned pending();
            return pending_dates.size();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got,
                                    logic [SECONDS_BITS-1:0] t);
            if (want != got) begin
                $display("%0t: %s mismatch for epoch %0d: expected %0d, actual %0d",
                         $time, name, t, want, got);
                errors++;
            end
        endfunction

        function void check_date(t_cal_date got);
            t_cal_date want;
            if (pending_dates.size() == 0) begin
                $display("%0t: result beat with nothing pending: expected none, actual %0d-%0d-%0d",
                         $time, got.year, got.month, got.mday);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            compare_field("year_since_1900", want.year, got.year, want.epoch);
            compare_field("month_index", want.month, got.month, want.epoch);
            compare_field("day_of_month", want.mday, got.mday, want.epoch);
            compare_field("hour_of_day", want.hour, got.hour, want.epoch);
            compare_field("minute_of_hour", want.minute, got.minute, want.epoch);
            compare_field("second_of_minute", want.second, got.second, want.epoch);
            compare_field("day_of_year", want.yday, got.yday, want.epoch);
            compare_field("weekday", want.wday, got.wday, want.epoch);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [SECONDS_BITS-1:0] i_epoch_seconds;
    logic                    o_valid;
    logic                    i_ready;
    logic [YEAR_W-1:0]       o_year_since_1900;
    logic [MONTH_W-1:0]      o_month_index;
    logic [MDAY_W-1:0]       o_day_of_month;
    logic [HOUR_W-1:0]       o_hour_of_day;
    logic [MIN_W-1:0]        o_minute_of_hour;
    logic [SEC_W-1:0]        o_second_of_minute;
    logic [YDAY_W-1:0]       o_day_of_year;
    logic [WDAY_W-1:0]       o_weekday;

    t_date_scoreboard sb;
    int               idle_pct;
    int               stall_pct;
    longint unsigned  cycle_count = 0;

    epoch_seconds_to_calendar_date #(
        .SECONDS_BITS(SECONDS_BITS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_year_since_1900  (o_year_since_1900),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute),
        .o_day_of_year      (o_day_of_year),
        .o_weekday          (o_weekday)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: ready decided at each falling edge
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cal_date got;
        if (i_rst_n && o_valid && i_ready) begin
            got.epoch  = '0;
            got.year   = o_year_since_1900;
            got.month  = o_month_index;
            got.mday   = o_day_of_month;
            got.hour   = o_hour_of_day;
            got.minute = o_minute_of_hour;
            got.second = o_second_of_minute;
            got.yday   = o_day_of_year;
            got.wday   = o_weekday;
            sb.check_date(got);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_epoch(input logic [SECONDS_BITS-1:0] t);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_epoch_seconds = t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_epoch(t);
        @(negedge i_clk);
    endtask

    // half plain random, half dates at or next to month edges with edge or random times of day
    function automatic logic [SECONDS_BITS-1:0] pick_epoch();
        longint unsigned s;
        int unsigned     y;
        int unsigned     m;
        int unsigned     d;
        int unsigned     len;
        if ($urandom_range(1)) begin
            return $urandom();
        end
        y   = $urandom_range(2106, 1970);
        m   = $urandom_range(11);
        len = t_date_scoreboard::month_len(t_date_scoreboard::leap_year(y), m);
        case ($urandom_range(3))
            0:       d = 1;
            1:       d = 2;
            2:       d = len - 1;
            default: d = len;
        endcase
        s = t_date_scoreboard::epoch_of(y, m, d);
        case ($urandom_range(2))
            0:       s += 0;
            1:       s += 86399;
            default: s += $urandom_range(86399);
        endcase
        if (s > MAX_EPOCH) begin
            return $urandom();
        end
        return s[SECONDS_BITS-1:0];
    endfunction

    initial begin
        logic [SECONDS_BITS-1:0] directed_q[$];
        sb              = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_epoch_seconds = '0;
        idle_pct        = 0;
        stall_pct       = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_q.push_back(32'd0);
        directed_q.push_back(32'd1);
        directed_q.push_back(32'd86399);
        directed_q.push_back(32'd86400);
        directed_q.push_back(32'hFFFF_FFFF);
        directed_q.push_back(32'h7FFF_FFFF);
        directed_q.push_back(32'h8000_0000);
        directed_q.push_back(32'hAAAA_AAAA);
        directed_q.push_back(32'h5555_5555);
        // last second of a year and first of the next
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(1970, 11, 31) + 86399));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(1971, 0, 1)));
        // leap day, the day after, and day 365 of a leap year
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(1972, 1, 29)));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(1972, 2, 1)));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(1972, 11, 31) + 43200));
        // century rules: 2000 is leap, 2100 is not
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(2000, 1, 29) + 3599));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(2000, 11, 31) + 86399));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(2100, 1, 28) + 86399));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(2100, 2, 1)));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(2104, 11, 31) + 86399));
        // last day of a 30-day month and of a 31-day month
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(1999, 3, 30) + 59));
        directed_q.push_back(32'(t_date_scoreboard::epoch_of(2024, 6, 31) + 3600));
        foreach (directed_q[k]) begin
            send_epoch(directed_q[k]);
        end

        for (int p = 0; p < 4; p++) begin
            idle_pct  = PHASE_IDLE[p];
            stall_pct = PHASE_STALL[p];
            repeat (RANDOM_PER_PHASE) send_epoch(pick_epoch());
        end
        i_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
